>>> design/pps_pkg.sv
// Shared types and constants for the preemptive priority scheduler.
// Holds the input and result transfer structs and the task table entry.
// No dependencies.
package pps_pkg;

    localparam int unsigned DEF_MAX_TASKS = 16;
    localparam int unsigned SLOT_W        = 4;
    localparam int unsigned TIME_W        = 32;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    // Operation codes carried in the operation field.
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef struct packed {
        logic        operation;
        logic [15:0] arrival_time;
        logic [15:0] burst_time;
        logic [7:0]  task_priority;
    } t_in_item;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              idle;
        logic              rejected;
        logic              finished;
        logic [TIME_W-1:0] finish_time;
        logic [TIME_W-1:0] turnaround;
        logic [TIME_W-1:0] waiting;
        logic              all_done;
    } t_out_item;

    typedef struct packed {
        logic [15:0] arrival;
        logic [15:0] burst;
        logic [7:0]  prio;
        logic [15:0] remaining;
    } t_task_entry;

endpackage

>>> design/preemptive_priority_scheduler.sv
// Preemptive priority scheduler: task table in a memory with a single read port, scanned by a sequencer.
// Depends on pps_pkg for the transfer structs, the table entry and the op codes.
//
//  channel | direction | handshake                   | payload
//  --------+-----------+-----------------------------+-----------------------
//  in      | input     | i_in_valid / o_in_ready     | i_in_data  (t_in_item)
//  out     | output    | o_out_valid / i_out_ready   | o_out_data (t_out_item)
//
// A load goes from its transfer to S_OUT and then into the result register once the
// output register is free. A tick steps through S_SCAN, S_DRAIN, S_UPD, S_FIN and S_OUT
// (an empty table skips S_SCAN and S_DRAIN): one table entry is read per cycle through
// the single read port and goes through one shared priority comparator. The next
// transfer in can come in the cycle after the result register loads.
// Reset (i_rst_n low, synchronous) empties the table and zeroes time and counters.
// A result waiting on the out channel does not stop the next transfer in; it
// only holds the sequencer in its final state until the output register frees.
module preemptive_priority_scheduler
    import pps_pkg::*;
#(
    parameter int unsigned MAX_TASKS = DEF_MAX_TASKS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    localparam int unsigned IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int unsigned CNT_W = $clog2(MAX_TASKS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TASKS);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_UPD   = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    // Task table.
    t_task_entry r_mem [MAX_TASKS];
    t_task_entry r_rd;

    logic [2:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_task_cnt, n_task_cnt;
    logic [CNT_W-1:0]  r_done_cnt, n_done_cnt;
    logic [TIME_W-1:0] r_time, n_time;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic              r_cmp_vld, n_cmp_vld;
    logic [IDX_W-1:0]  r_cmp_idx, n_cmp_idx;
    logic              r_found, n_found;
    logic [IDX_W-1:0]  r_best_idx, n_best_idx;
    t_task_entry       r_best, n_best;
    logic [TIME_W-1:0] r_tat, n_tat;
    logic [TIME_W-1:0] r_wait, n_wait;
    logic [SLOT_W-1:0] r_res_slot, n_res_slot;
    logic              r_res_idle, n_res_idle;
    logic              r_res_rej, n_res_rej;
    logic              r_res_fin, n_res_fin;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out, n_out;

    logic              accept;
    logic              we;
    logic [IDX_W-1:0]  waddr;
    t_task_entry       wdata;
    logic              elig;
    logic [15:0]       rem_dec;
    logic [TIME_W-1:0] time_inc;
    logic [CNT_W-1:0]  last_idx;

    assign o_in_ready  = (r_state == S_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign rem_dec  = r_best.remaining - 16'd1;
    assign time_inc = (r_time == TIME_MAX) ? r_time : r_time + TIME_W'(1);
    assign last_idx = r_task_cnt - CNT_W'(1);

    // Shared comparator: the entry read last cycle against the best so far.
    assign elig = (TIME_W'(r_rd.arrival) <= r_time) && (r_rd.remaining != 16'd0) &&
                  (!r_found || (r_rd.prio < r_best.prio));

    always_comb begin
        n_state     = r_state;
        n_task_cnt  = r_task_cnt;
        n_done_cnt  = r_done_cnt;
        n_time      = r_time;
        n_idx       = r_idx;
        n_cmp_vld   = 1'b0;
        n_cmp_idx   = r_idx;
        n_found     = r_found;
        n_best_idx  = r_best_idx;
        n_best      = r_best;
        n_tat       = r_tat;
        n_wait      = r_wait;
        n_res_slot  = r_res_slot;
        n_res_idle  = r_res_idle;
        n_res_rej   = r_res_rej;
        n_res_fin   = r_res_fin;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        we          = 1'b0;
        waddr       = r_task_cnt[IDX_W-1:0];
        wdata       = '{arrival:   i_in_data.arrival_time,
                        burst:     i_in_data.burst_time,
                        prio:      i_in_data.task_priority,
                        remaining: i_in_data.burst_time};

        if (r_cmp_vld && elig) begin
            n_found    = 1'b1;
            n_best_idx = r_cmp_idx;
            n_best     = r_rd;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_res_idle = 1'b0;
                    n_res_fin  = 1'b0;
                    n_res_rej  = 1'b0;
                    n_res_slot = '0;
                    if (i_in_data.operation == OP_LOAD) begin
                        if ((r_task_cnt >= CNT_MAX) || (i_in_data.burst_time == 16'd0)) begin
                            n_res_rej = 1'b1;
                        end else begin
                            we         = 1'b1;
                            n_res_slot = SLOT_W'(r_task_cnt[IDX_W-1:0]);
                            n_task_cnt = r_task_cnt + CNT_W'(1);
                        end
                        n_state = S_OUT;
                    end else begin
                        n_found = 1'b0;
                        n_idx   = '0;
                        n_state = (r_task_cnt == '0) ? S_UPD : S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                n_cmp_vld = 1'b1;
                n_cmp_idx = r_idx;
                if (r_idx == last_idx[IDX_W-1:0]) begin
                    n_state = S_DRAIN;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_DRAIN: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                n_time = time_inc;
                n_tat  = time_inc - TIME_W'(r_best.arrival);
                if (r_found) begin
                    we              = 1'b1;
                    waddr           = r_best_idx;
                    wdata           = r_best;
                    wdata.remaining = rem_dec;
                    n_res_slot      = SLOT_W'(r_best_idx);
                    n_res_fin       = (rem_dec == 16'd0);
                    if (rem_dec == 16'd0) begin
                        n_done_cnt = r_done_cnt + CNT_W'(1);
                    end
                end else begin
                    n_res_idle = 1'b1;
                end
                n_state = S_FIN;
            end
            S_FIN: begin
                // Saturated time can leave turnaround below the burst.
                n_wait  = (r_tat >= TIME_W'(r_best.burst)) ?
                          (r_tat - TIME_W'(r_best.burst)) : '0;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid       = 1'b1;
                    n_out.slot        = r_res_slot;
                    n_out.idle        = r_res_idle;
                    n_out.rejected    = r_res_rej;
                    n_out.finished    = r_res_fin;
                    n_out.finish_time = r_res_fin ? r_time : '0;
                    n_out.turnaround  = r_res_fin ? r_tat : '0;
                    n_out.waiting     = r_res_fin ? r_wait : '0;
                    n_out.all_done    = (r_task_cnt != '0) && (r_done_cnt == r_task_cnt);
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        r_rd <= r_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_task_cnt  <= '0;
            r_done_cnt  <= '0;
            r_time      <= '0;
            r_cmp_vld   <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_task_cnt  <= n_task_cnt;
            r_done_cnt  <= n_done_cnt;
            r_time      <= n_time;
            r_cmp_vld   <= n_cmp_vld;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_cmp_idx  <= n_cmp_idx;
        r_best_idx <= n_best_idx;
        r_best     <= n_best;
        r_tat      <= n_tat;
        r_wait     <= n_wait;
        r_res_slot <= n_res_slot;
        r_res_idle <= n_res_idle;
        r_res_rej  <= n_res_rej;
        r_res_fin  <= n_res_fin;
        r_out      <= n_out;
    end

    a_done_le_tasks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done_cnt <= r_task_cnt)
        else $error("finished count exceeds loaded count");

    a_cmp_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmp_vld |-> (r_state == S_DRAIN) || (r_state == S_SCAN))
        else $error("comparator active outside the table scan");

    a_best_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_found |-> (CNT_W'(r_best_idx) < r_task_cnt))
        else $error("selected slot lies beyond the loaded tasks");

    a_result_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.finished |-> !o_out_data.idle && !o_out_data.rejected)
        else $error("finished result also flagged idle or rejected");

    a_time_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) |=> (r_time == $past(time_inc)))
        else $error("time did not advance on a tick");

endmodule
